// ===== rtl/utu_pkg.sv =====
// shared types, constants and helper functions of the utf-8 to utf-16 transcoder
package utu_pkg;

  // width of the running unit counter
  localparam int COUNT_BITS = 16;
  // width used to compare the counter against the 16-bit capacity
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // job queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(1);

  // mode codes
  localparam logic MODE_CONVERT = 1'b0;
  localparam logic MODE_LENGTH = 1'b1;

  // second byte class codes
  localparam logic [2:0] CLS_ANY = 3'd0;
  localparam logic [2:0] CLS_E0 = 3'd1;
  localparam logic [2:0] CLS_ED = 3'd2;
  localparam logic [2:0] CLS_F0 = 3'd3;
  localparam logic [2:0] CLS_F4 = 3'd4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        done_res;
    status_t     status;
    logic [15:0] unit_count;
    logic        last_result;
  } out_item_t;

  // work for the back end: up to two units, then an optional done word
  typedef struct packed {
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic [1:0]  n_units;
    logic        done;
    status_t     status;
    logic [15:0] count;
  } job_t;

  // lowest continuation byte allowed for a class
  function automatic logic [7:0] cont_lo(input logic [2:0] cls);
    logic [7:0] lo;
    case (cls)
      CLS_E0:  lo = 8'hA0;
      CLS_F0:  lo = 8'h90;
      default: lo = 8'h80;
    endcase
    return lo;
  endfunction

  // highest continuation byte allowed for a class
  function automatic logic [7:0] cont_hi(input logic [2:0] cls);
    logic [7:0] hi;
    case (cls)
      CLS_ED:  hi = 8'h9F;
      CLS_F4:  hi = 8'h8F;
      default: hi = 8'hBF;
    endcase
    return hi;
  endfunction

endpackage

// ===== rtl/utu_front.sv =====
// front end: takes bytes, decodes utf-8 and queues jobs for units and ends
module utu_front import utu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic        mode,
  input  logic [15:0] capacity,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [20:0]           acc_r, acc_nxt;
  logic [1:0]            rem_r, rem_nxt;
  logic [2:0]            cls_r, cls_nxt;
  logic                  discard_r, discard_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic                  accept;
  logic                  err, complete, fin;
  status_t               st;
  logic [7:0]            b;
  logic [20:0]           acc_v, adj;
  logic [COUNT_BITS-1:0] cnt_v;
  logic [COUNT_BITS:0]   sum1, sum2;
  logic [COUNT_BITS-1:0] sat1, sat2;
  logic [CMP_W:0]        cnt_ext, cnt_p1_ext, cap_ext;
  logic [CMP_W-1:0]      cnt_wide;
  logic [1:0]            rem_v;
  logic [2:0]            cls_v;
  job_t                  job;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;
  assign b        = in_data.data_byte;
  assign fin      = in_data.final_byte;

  // counter arithmetic: saturating adds and capacity compares
  assign sum1       = {1'b0, cnt_r} + (COUNT_BITS+1)'(1);
  assign sum2       = {1'b0, cnt_r} + (COUNT_BITS+1)'(2);
  assign sat1       = sum1[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum1[COUNT_BITS-1:0];
  assign sat2       = sum2[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum2[COUNT_BITS-1:0];
  assign cnt_ext    = (CMP_W+1)'(cnt_r);
  assign cnt_p1_ext = cnt_ext + (CMP_W+1)'(1);
  assign cap_ext    = (CMP_W+1)'(capacity);

  // decode of one byte against the current sequence state
  always_comb begin
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    cls_nxt     = cls_r;
    discard_nxt = discard_r;
    cnt_nxt     = cnt_r;
    err         = 1'b0;
    complete    = 1'b0;
    st          = ST_OK;
    acc_v       = acc_r;
    rem_v       = rem_r;
    cls_v       = cls_r;
    cnt_v       = cnt_r;
    adj         = '0;
    cnt_wide    = '0;
    job         = '0;

    if (discard_r) begin
      if (fin) begin
        discard_nxt = 1'b0;
        acc_nxt     = '0;
        rem_nxt     = '0;
        cls_nxt     = CLS_ANY;
        cnt_nxt     = '0;
      end
    end else begin
      if (rem_r == 2'd0) begin
        if (mode == MODE_CONVERT && cnt_ext >= cap_ext) begin
          err = 1'b1;
          st  = ST_NOSPACE;
        end else if (b < 8'h80) begin
          acc_v    = 21'(b);
          complete = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          acc_v = 21'(b[4:0]);
          rem_v = 2'd1;
          cls_v = CLS_ANY;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          acc_v = 21'(b[3:0]);
          rem_v = 2'd2;
          cls_v = (b == 8'hE0) ? CLS_E0 : (b == 8'hED) ? CLS_ED : CLS_ANY;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          acc_v = 21'(b[2:0]);
          rem_v = 2'd3;
          cls_v = (b == 8'hF0) ? CLS_F0 : (b == 8'hF4) ? CLS_F4 : CLS_ANY;
        end else begin
          err = 1'b1;
          st  = ST_INVALID;
        end
      end else begin
        if (b < cont_lo(cls_r) || b > cont_hi(cls_r)) begin
          err = 1'b1;
          st  = ST_INVALID;
        end else begin
          acc_v = {acc_r[14:0], b[5:0]};
          cls_v = CLS_ANY;
          rem_v = rem_r - 2'd1;
          if (rem_r == 2'd1) begin
            complete = 1'b1;
          end
        end
      end

      // finished code point: emit or count units
      if (!err && complete) begin
        adj = acc_v - 21'h010000;
        if (acc_v < 21'h010000) begin
          if (mode == MODE_CONVERT) begin
            job.unit_a  = acc_v[15:0];
            job.n_units = 2'd1;
          end
          cnt_v = sat1;
        end else if (mode == MODE_CONVERT) begin
          if (cnt_p1_ext >= cap_ext) begin
            err = 1'b1;
            st  = ST_NOSPACE;
          end else begin
            job.unit_a  = {6'b110110, adj[19:10]};
            job.unit_b  = {6'b110111, adj[9:0]};
            job.n_units = 2'd2;
            cnt_v       = sat2;
          end
        end else begin
          cnt_v = sat2;
        end
        acc_v = '0;
      end

      // truncated sequence at the end of the message
      if (!err && fin && rem_v != 2'd0) begin
        err = 1'b1;
        st  = ST_INVALID;
      end

      cnt_wide = CMP_W'(cnt_v);
      if (err || fin) begin
        job.done    = 1'b1;
        job.status  = st;
        job.count   = cnt_wide[15:0];
        acc_nxt     = '0;
        rem_nxt     = '0;
        cls_nxt     = CLS_ANY;
        cnt_nxt     = '0;
        discard_nxt = err & ~fin;
      end else begin
        acc_nxt = acc_v;
        rem_nxt = rem_v;
        cls_nxt = cls_v;
        cnt_nxt = cnt_v;
      end
    end
  end

  assign q_job  = job;
  assign q_push = accept & (job.done | (job.n_units != 2'd0));

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      rem_r     <= '0;
      cls_r     <= CLS_ANY;
      discard_r <= 1'b0;
      cnt_r     <= '0;
    end else if (accept) begin
      acc_r     <= acc_nxt;
      rem_r     <= rem_nxt;
      cls_r     <= cls_nxt;
      discard_r <= discard_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/utu_queue.sv =====
// short job queue between the decoder and the result sequencer
module utu_queue import utu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/utu_back.sv =====
// back end: walks jobs, one result word per cycle while out_ready is high
module utu_back import utu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       load, last;
  logic [1:0] total;

  assign total = head_job.n_units + 2'(head_job.done);
  assign last  = (step_r == total - 2'd1);
  assign load  = head_valid & (~out_valid_r | out_ready);
  assign pop   = load & last;

  // pick the result at the current step of the head job
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    step_nxt      = step_r;
    if (load) begin
      out_nxt = '0;
      if (step_r < head_job.n_units) begin
        out_nxt.code_unit  = (step_r == 2'd0) ? head_job.unit_a : head_job.unit_b;
        out_nxt.unit_valid = 1'b1;
      end else begin
        out_nxt.done_res   = 1'b1;
        out_nxt.status     = head_job.status;
        out_nxt.unit_count = head_job.count;
      end
      out_nxt.last_result = last;
      out_valid_nxt       = 1'b1;
      step_nxt            = last ? 2'd0 : step_r + 2'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/utu_to_utf16_top_note.sv =====
// configuration register file of the transcoder
module utu_cfg import utu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  mode,
  output logic [15:0]           capacity
);

  logic        mode_r;
  logic [15:0] cap_r;

  assign cfg_ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CONVERT;
      cap_r  <= 16'hFFFF;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MODE) begin
        mode_r <= cfg_wdata[0];
      end else if (cfg_index == REG_CAPACITY) begin
        cap_r <= cfg_wdata[15:0];
      end
    end
  end

  assign mode     = mode_r;
  assign capacity = cap_r;

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// top level of the streaming utf-8 to utf-16 transcoder
// Takes one UTF-8 byte per cycle while in_ready is high and returns UTF-16
// units and a closing done word with status and unit count. The decoder
// accepts a byte every cycle as long as its four-entry job queue has room;
// each byte turns into zero to three result words, which the output register
// hands out at one word per cycle while out_ready is high. The queue lets
// bursts of pair-producing bytes be absorbed while the output side is
// stalled. Mode and capacity must be written through the cfg port only while
// the block is idle, which the block does not enforce; cfg_ready is tied high.
module utf8_to_utf16_transcoder import utu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        mode;
  logic [15:0] capacity;
  logic        q_full, q_push, q_pop, q_head_valid;
  job_t        q_job, q_head;

  utu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mode      (mode),
    .capacity  (capacity)
  );

  utu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .mode     (mode),
    .capacity (capacity),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  utu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  utu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
